@@ hw/rtl/mm31_pkg.sv @@
package mm31_pkg;

   localparam int unsigned DataWidth = 31;

   // the prime 2^31 - 1
   localparam logic [DataWidth-1:0] ModP = 31'h7FFF_FFFF;

   // operation codes
   localparam logic [1:0] MODE_ADD = 2'd0;
   localparam logic [1:0] MODE_SUB = 2'd1;
   localparam logic [1:0] MODE_MUL = 2'd2;
   localparam logic [1:0] MODE_DIV = 2'd3;

   typedef logic [DataWidth-1:0] data_type;

   // core -> top status
   typedef struct packed {
      logic idle;      // ready for a new word
      logic done;      // result held, waiting for ack
      logic zero_div;  // divide by a zero divisor
   } core_status_type;

   // x / 2 modulo P, x in 0..P-1
   function automatic data_type half_mod(input data_type x);
      logic [DataWidth:0] s;
      begin
         s = x[0] ? ({1'b0, x} + {1'b0, ModP}) : {1'b0, x};
         return s[DataWidth:1];
      end
   endfunction

   // (x - y) modulo P, x and y in 0..P-1
   function automatic data_type sub_mod(input data_type x, input data_type y);
      begin
         if (x >= y) begin
            return x - y;
         end else begin
            return DataWidth'(({1'b0, x} + {1'b0, ModP}) - {1'b0, y});
         end
      end
   endfunction

endpackage

@@ hw/rtl/mm31_core.sv @@
module mm31_core
   import mm31_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [1:0]      mode,
   input  data_type        operand_a,
   input  data_type        operand_b,
   input  logic            ack,
   output core_status_type status,
   output data_type        result
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ADD  = 3'd1;
   localparam logic [2:0] S_INV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_FOLD = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [1:0]  mode_ff, mode_in;
   data_type    a_ff, a_in;
   data_type    u_ff, u_in;     // divisor / inverse loop / 2nd multiplicand
   data_type    v_ff, v_in;
   data_type    x1_ff, x1_in;
   data_type    x2_ff, x2_in;
   logic [2*DataWidth-1:0] prod_ff, prod_in;
   logic [DataWidth:0]     fold_ff, fold_in;
   data_type    res_ff, res_in;
   logic        zd_ff, zd_in;

   data_type           a_red, b_red;
   logic [DataWidth:0] sum;
   logic [DataWidth:0] fold2;

   // an operand equal to P reduces to 0
   assign a_red = (operand_a == ModP) ? '0 : operand_a;
   assign b_red = (operand_b == ModP) ? '0 : operand_b;

   assign sum   = {1'b0, a_ff} + {1'b0, u_ff};
   assign fold2 = {1'b0, fold_ff[DataWidth-1:0]} + {{DataWidth{1'b0}}, fold_ff[DataWidth]};

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      a_in     = a_ff;
      u_in     = u_ff;
      v_in     = v_ff;
      x1_in    = x1_ff;
      x2_in    = x2_ff;
      prod_in  = prod_ff;
      fold_in  = fold_ff;
      res_in   = res_ff;
      zd_in    = zd_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = mode;
               a_in    = a_red;
               u_in    = b_red;
               v_in    = ModP;
               x1_in   = DataWidth'(1);
               x2_in   = '0;
               zd_in   = 1'b0;
               case (mode)
                  MODE_ADD, MODE_SUB: state_in = S_ADD;
                  MODE_MUL:           state_in = S_MUL;
                  default: begin
                     if (b_red == '0) begin
                        zd_in    = 1'b1;
                        res_in   = '0;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_INV;
                     end
                  end
               endcase
            end
         end
         S_ADD: begin
            if (mode_ff == MODE_ADD) begin
               res_in = (sum >= {1'b0, ModP}) ? DataWidth'(sum - {1'b0, ModP})
                                              : sum[DataWidth-1:0];
            end else begin
               res_in = sub_mod(a_ff, u_ff);
            end
            state_in = S_DONE;
         end
         S_INV: begin
            // binary extended gcd, one step per cycle
            if (u_ff == DataWidth'(1)) begin
               state_in = S_MUL;
               u_in     = x1_ff;
            end else if (v_ff == DataWidth'(1)) begin
               state_in = S_MUL;
               u_in     = x2_ff;
            end else if (!u_ff[0]) begin
               u_in  = u_ff >> 1;
               x1_in = half_mod(x1_ff);
            end else if (!v_ff[0]) begin
               v_in  = v_ff >> 1;
               x2_in = half_mod(x2_ff);
            end else if (u_ff >= v_ff) begin
               u_in  = u_ff - v_ff;
               x1_in = sub_mod(x1_ff, x2_ff);
            end else begin
               v_in  = v_ff - u_ff;
               x2_in = sub_mod(x2_ff, x1_ff);
            end
         end
         S_MUL: begin
            prod_in  = (2*DataWidth)'(a_ff) * (2*DataWidth)'(u_ff);
            state_in = S_FOLD;
         end
         S_FOLD: begin
            // 2^31 == 1 mod P
            fold_in  = {1'b0, prod_ff[DataWidth-1:0]} + {1'b0, prod_ff[2*DataWidth-1:DataWidth]};
            state_in = S_FIN;
         end
         S_FIN: begin
            res_in = (fold2 >= {1'b0, ModP}) ? DataWidth'(fold2 - {1'b0, ModP})
                                             : fold2[DataWidth-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      a_ff    <= a_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      x1_ff   <= x1_in;
      x2_ff   <= x2_in;
      prod_ff <= prod_in;
      fold_ff <= fold_in;
      res_ff  <= res_in;
      zd_ff   <= zd_in;
   end

   assign status.idle     = (state_ff == S_IDLE);
   assign status.done     = (state_ff == S_DONE);
   assign status.zero_div = zd_ff;
   assign result          = res_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == S_IDLE)
      else $error("start outside idle");

   a_inv_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INV |-> (u_ff != '0 && v_ff != '0))
      else $error("gcd operand reached zero");

   a_res_range: assert property (@(posedge clock) disable iff (reset)
      status.done |-> res_ff != ModP)
      else $error("result not reduced");

   a_zd_zero: assert property (@(posedge clock) disable iff (reset)
      (status.done && zd_ff) |-> (res_ff == '0 && mode_ff == MODE_DIV))
      else $error("zero divisor with nonzero result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (status.done && !ack) |=> (status.done && $stable(res_ff) && $stable(zd_ff)))
      else $error("result lost before ack");

endmodule

@@ hw/rtl/modular_arith_mod_2_31_minus_1.sv @@
// Arithmetic unit over the integers modulo P = 2^31 - 1.
//
// Request channel (req_valid/req_ready): one word carries a mode (add, subtract,
// multiply, divide) and two 31-bit operands; an operand equal to P counts as 0.
// Response channel (rsp_valid/rsp_ready): one word per request with the result
// in 0..P-1 and zero_divisor, set (with result 0) on a divide by zero.
//
// Path from accept to rsp_valid, through the core and then the output register:
//   add / subtract  one add or subtract step
//   multiply        31x31 product, then two fold stages
//   divide by zero  flagged at accept with result 0, no core step
//   divide          the inverse comes from a binary extended gcd that takes
//                   one halve or subtract step a cycle, followed by the
//                   multiply and its fold stages.
// One request is in the core at a time: req_ready is high only while it is idle.
// The core goes idle on the edge that moves its result out, so a new word is
// taken only once the last word's result has left the core.
// A finished result moves to the output register; if the receiver stalls with a
// word already there, the core holds its result and takes no new request.
// Reset (synchronous, active high) empties the core and the output register.
module modular_arith_mod_2_31_minus_1
   import mm31_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [30:0] req_operand_a,
   input  logic [30:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_result,
   output logic        rsp_zero_divisor
);

   core_status_type core_status;
   data_type        core_result;
   logic            core_start;
   logic            core_ack;

   logic            rsp_valid_ff, rsp_valid_in;
   data_type        rsp_result_ff, rsp_result_in;
   logic            rsp_zd_ff, rsp_zd_in;

   // accept a word only when the core sits idle
   assign req_ready  = core_status.idle;
   assign core_start = req_valid && req_ready;

   // move the core's result out when the output register is free or draining
   assign core_ack = core_status.done && (!rsp_valid_ff || rsp_ready);

   mm31_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .mode      (req_mode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .ack       (core_ack),
      .status    (core_status),
      .result    (core_result)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_zd_in     = rsp_zd_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (core_ack) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = core_result;
         rsp_zd_in     = core_status.zero_div;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      rsp_result_ff <= rsp_result_in;
      rsp_zd_ff     <= rsp_zd_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result       = rsp_result_ff;
   assign rsp_zero_divisor = rsp_zd_ff;

endmodule

@@ tb/modular_arith_mod_2_31_minus_1_test.sv @@
module modular_arith_mod_2_31_minus_1_test
   import mm31_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // ---- run shape --------------------------------------------------------
   localparam int ClockPeriod    = 10;
   localparam int ResetCycles    = 10;
   localparam int RandomWords    = 650;
   localparam int SteadyWords    = 100;     // tail of the run with no idling
   localparam int LongHoldAt     = 150;     // random word at which the long stall starts
   localparam int LongHoldCycles = 400;
   localparam int DrainCycles    = 200;
   localparam int CycleLimit     = 1000000;

   // 64-bit copy of the prime for the predictor arithmetic
   localparam logic [63:0] PrimeWide = {33'd0, ModP};

   // one row of the directed table; fixed = typed-in answer, else predicted
   typedef struct packed {
      logic [1:0] mode;
      data_type   a;
      data_type   b;
      logic       fixed;
      data_type   res;
      logic       zd;
   } dir_row_type;

   // one response word as it should come out
   typedef struct packed {
      data_type result;
      logic     zero_divisor;
   } rsp_word_type;

   localparam int NumDirected = 25;
   localparam dir_row_type DirTable [NumDirected] = '{
      // add: zeros, wraparound, operand equal to P, largest sum
      '{MODE_ADD, 31'h0000_0000, 31'h0000_0000, 1'b1, 31'h0000_0000, 1'b0},
      '{MODE_ADD, 31'h7FFF_FFFE, 31'h0000_0001, 1'b1, 31'h0000_0000, 1'b0},
      '{MODE_ADD, 31'h7FFF_FFFF, 31'h0000_0005, 1'b1, 31'h0000_0005, 1'b0},
      '{MODE_ADD, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFD, 1'b0},
      '{MODE_ADD, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, 1'b0},
      // subtract: borrow, equal, P as operand
      '{MODE_SUB, 31'h0000_0000, 31'h0000_0001, 1'b1, 31'h7FFF_FFFE, 1'b0},
      '{MODE_SUB, 31'h0000_0005, 31'h0000_0005, 1'b1, 31'h0000_0000, 1'b0},
      '{MODE_SUB, 31'h0000_0000, 31'h7FFF_FFFE, 1'b1, 31'h0000_0001, 1'b0},
      '{MODE_SUB, 31'h7FFF_FFFF, 31'h0000_0003, 1'b1, 31'h7FFF_FFFC, 1'b0},
      // multiply: (-1)^2, P as operand, 2^31 folds to 1
      '{MODE_MUL, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 1'b1, 31'h0000_0001, 1'b0},
      '{MODE_MUL, 31'h7FFF_FFFF, 31'h0000_007B, 1'b1, 31'h0000_0000, 1'b0},
      '{MODE_MUL, 31'h4000_0000, 31'h0000_0002, 1'b1, 31'h0000_0001, 1'b0},
      '{MODE_MUL, 31'h0000_0001, 31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFE, 1'b0},
      // divide: zero divisor (plain 0 and P), trivial inverses
      '{MODE_DIV, 31'h0000_0005, 31'h0000_0000, 1'b1, 31'h0000_0000, 1'b1},
      '{MODE_DIV, 31'h0000_0005, 31'h7FFF_FFFF, 1'b1, 31'h0000_0000, 1'b1},
      '{MODE_DIV, 31'h7FFF_FFFF, 31'h0000_0000, 1'b1, 31'h0000_0000, 1'b1},
      '{MODE_DIV, 31'h0000_0007, 31'h0000_0001, 1'b1, 31'h0000_0007, 1'b0},
      '{MODE_DIV, 31'h0000_0001, 31'h7FFF_FFFE, 1'b1, 31'h7FFF_FFFE, 1'b0},
      '{MODE_DIV, 31'h0000_0000, 31'h0000_0009, 1'b1, 31'h0000_0000, 1'b0},
      '{MODE_DIV, 31'h0000_0001, 31'h0000_0002, 1'b1, 31'h4000_0000, 1'b0},
      '{MODE_DIV, 31'h7FFF_FFFE, 31'h7FFF_FFFE, 1'b1, 31'h0000_0001, 1'b0},
      // predicted rows
      '{MODE_ADD, 31'h5555_5555, 31'h2AAA_AAAA, 1'b0, 31'h0000_0000, 1'b0},
      '{MODE_MUL, 31'h1234_5678, 31'h5A5A_5A5A, 1'b0, 31'h0000_0000, 1'b0},
      '{MODE_DIV, 31'h0000_3039, 31'h0000_02A6, 1'b0, 31'h0000_0000, 1'b0},
      '{MODE_SUB, 31'h2AAA_AAAA, 31'h5555_5555, 1'b0, 31'h0000_0000, 1'b0}
   };

   localparam logic [1:0] ModeList [4] = '{MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV};

   // ---- DUT ports ----------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_mode;
   data_type    req_operand_a;
   data_type    req_operand_b;
   logic        rsp_valid;
   logic        rsp_ready;
   data_type    rsp_result;
   logic        rsp_zero_divisor;

   modular_arith_mod_2_31_minus_1 DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_zero_divisor (rsp_zero_divisor)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // ---- shared testbench state --------------------------------------------
   rsp_word_type pending_results [$];   // answers owed by the block, oldest first
   int        error_count = 0;
   int        cycle_count = 0;
   int        words_by_mode [4] = '{0, 0, 0, 0};
   int        zero_div_words = 0;
   int        rsp_words = 0;
   int        long_holds_done = 0;
   bit        steady_phase = 1'b0;    // no idling on either side
   bit        long_hold_pending = 1'b0;

   // the word currently offered: typed-in answer if the row has one
   logic         cur_fixed = 1'b0;
   rsp_word_type cur_fixed_word = '0;

   // ---- predictor: arithmetic modulo 2^31 - 1 ------------------------------
   // fold twice (2^31 == 1 mod P), then one conditional subtract
   function automatic data_type fold_mod_p(input logic [63:0] v);
      logic [63:0] t;
      t = (v & PrimeWide) + (v >> 31);
      t = (t & PrimeWide) + (t >> 31);
      if (t >= PrimeWide) t = t - PrimeWide;
      return t[30:0];
   endfunction

   function automatic data_type mul_mod_p(input data_type x, input data_type y);
      return fold_mod_p({33'd0, x} * {33'd0, y});
   endfunction

   // Fermat: b^(P-2) is the inverse of a nonzero b
   function automatic data_type inv_mod_p(input data_type b);
      logic [63:0] e;
      data_type    acc;
      data_type    base;
      e    = PrimeWide - 64'd2;
      acc  = 31'd1;
      base = b;
      while (e != 64'd0) begin
         if (e[0]) acc = mul_mod_p(acc, base);
         base = mul_mod_p(base, base);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic rsp_word_type predict_word(input logic [1:0] mode,
                                                 input data_type a_in,
                                                 input data_type b_in);
      data_type     a;
      data_type     b;
      rsp_word_type w;
      a = fold_mod_p({33'd0, a_in});
      b = fold_mod_p({33'd0, b_in});
      w = '0;
      case (mode)
         MODE_ADD: w.result = fold_mod_p({33'd0, a} + {33'd0, b});
         MODE_SUB: w.result = fold_mod_p(PrimeWide + {33'd0, a} - {33'd0, b});
         MODE_MUL: w.result = mul_mod_p(a, b);
         default: begin
            if (b == '0) begin
               w.zero_divisor = 1'b1;
            end else begin
               w.result = mul_mod_p(a, inv_mod_p(b));
            end
         end
      endcase
      return w;
   endfunction

   // random operand: full range three times in eight, else an edge or small value
   function automatic data_type pick_operand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ModP;                       // reduces to zero
         2: return ModP - 31'd1;
         3: return data_type'($urandom_range(1, 300));
         4: return data_type'(1) << $urandom_range(0, 30);
         default: return data_type'($urandom);
      endcase
   endfunction

   // ---- monitor: both handshakes at the rising edge ------------------------
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         // request word taken: log what it must produce
         if (req_valid && req_ready) begin
            want = cur_fixed ? cur_fixed_word
                             : predict_word(req_mode, req_operand_a, req_operand_b);
            pending_results.push_back(want);
            words_by_mode[req_mode]++;
            if (want.zero_divisor) zero_div_words++;
         end
         // response word taken: compare against the oldest answer owed
         if (rsp_valid && rsp_ready) begin
            rsp_words++;
            if (pending_results.size() == 0) begin
               $display("%0t: response word with none outstanding: result %h zero_divisor %b",
                        $time, rsp_result, rsp_zero_divisor);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_result !== want.result) begin
                  $display("%0t: result mismatch: expected %h, actual %h",
                           $time, want.result, rsp_result);
                  error_count++;
               end
               if (rsp_zero_divisor !== want.zero_divisor) begin
                  $display("%0t: zero_divisor mismatch: expected %b, actual %b",
                           $time, want.zero_divisor, rsp_zero_divisor);
                  error_count++;
               end
            end
         end
      end
   end

   // ---- watchdog -----------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pending_results.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---- receiver: rsp_ready with random stall bursts and one long hold -----
   initial begin
      int stall;
      int hold_count;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            // long hold-off: block fills up and must stall req_ready
            long_hold_pending = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_count = 0; hold_count < LongHoldCycles; hold_count++) @(negedge clock);
            rsp_ready <= 1'b1;
            long_holds_done++;
         end else if (!steady_phase && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---- sender: one request word, with an optional idle burst first ---------
   task automatic send_word(input logic [1:0] mode, input data_type a, input data_type b,
                            input logic fixed, input rsp_word_type fixed_word);
      int gap;
      if (!steady_phase && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      cur_fixed      = fixed;
      cur_fixed_word = fixed_word;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_operand_a <= a;
      req_operand_b <= b;
      // hold until taken
      do @(posedge clock); while (!req_ready);
   endtask

   // ---- main sequence ------------------------------------------------------
   initial begin
      logic [1:0]   mode;
      data_type     a;
      data_type     b;
      rsp_word_type typed;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_mode      = MODE_ADD;
      req_operand_a = '0;
      req_operand_b = '0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NumDirected; i++) begin
         typed.result       = DirTable[i].res;
         typed.zero_divisor = DirTable[i].zd;
         send_word(DirTable[i].mode, DirTable[i].a, DirTable[i].b, DirTable[i].fixed, typed);
      end

      // random words, all checked against the predictor
      for (int i = 0; i < RandomWords; i++) begin
         if (i == LongHoldAt) long_hold_pending = 1'b1;
         if (i == RandomWords - SteadyWords) steady_phase = 1'b1;
         mode = ModeList[$urandom_range(0, 3)];
         a    = pick_operand();
         b    = pick_operand();
         // extra divide-by-zero words
         if (mode == MODE_DIV && $urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? ModP : '0;
         send_word(mode, a, b, 1'b0, '0);
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then let any late stray word show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Covered %0d request words (add %0d, sub %0d, mul %0d, div %0d, %0d by zero),",
               words_by_mode[0] + words_by_mode[1] + words_by_mode[2] + words_by_mode[3],
               words_by_mode[MODE_ADD], words_by_mode[MODE_SUB], words_by_mode[MODE_MUL],
               words_by_mode[MODE_DIV], zero_div_words);
      $display("%0d response words checked, %0d long receiver hold-off(s) of %0d cycles.",
               rsp_words, long_holds_done, LongHoldCycles);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d words never answered",
                  error_count, pending_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/mm31_pkg.sv
hw/rtl/mm31_core.sv
hw/rtl/modular_arith_mod_2_31_minus_1.sv
tb/modular_arith_mod_2_31_minus_1_test.sv
